@@ rtl/gcad_pkg.sv @@
// ----------------------------------------------------------------------------
// gcad_pkg
// Shared types and constants of the GC-ADPCM decoder core.
// ----------------------------------------------------------------------------
package gcad_pkg;

	localparam int unsigned NUM_COEF_PAIRS = 8;
	localparam int unsigned COEF_IDX_W     = 3;
	localparam int unsigned CFG_INDEX_W    = 4;
	localparam int unsigned CFG_DATA_W     = 32;
	localparam int unsigned SHIFT_W        = 4;
	localparam int unsigned POS_W          = 3;
	localparam int unsigned SAMPLE_W       = 16;

	// filter arithmetic: 19-bit shifted nibble, 11 fraction bits, 35-bit sum
	localparam int unsigned NIB_EXT_W = 19;
	localparam int unsigned FRAC_W    = 11;
	localparam int unsigned ACC_W     = 35;
	localparam int unsigned RES_W     = ACC_W - FRAC_W;

	localparam logic signed [ACC_W-1:0] ROUND_BIAS = 35'sd1024;
	localparam logic signed [RES_W-1:0] SAT_MAX    = 24'sd32767;
	localparam logic signed [RES_W-1:0] SAT_MIN    = -24'sd32768;

	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_LOW  = 1'b1
	} gcad_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_hist;
		logic load_hdr;
		logic calc_hi;
		logic calc_lo;
	} gcad_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic header_next;
	} gcad_status_t;

endpackage

@@ rtl/gcad_ctrl.sv @@
// ----------------------------------------------------------------------------
// gcad_ctrl
// Sequencer of the decoder: input handshake, nibble order, output valid.
// ----------------------------------------------------------------------------
module gcad_ctrl
	import gcad_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic         kind,
	input  logic         frame_start,
	output logic         out_valid,
	input  logic         out_stall,
	input  gcad_status_t status,
	output gcad_cmd_t    cmd
);

	gcad_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;
	logic        in_beat;

	// output register can take a new sample this cycle
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= (cmd.calc_hi || cmd.calc_lo) || (out_valid_q && out_stall);
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		in_beat  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = !out_free;
				in_beat  = in_valid && out_free;
				if (in_beat) begin
					if (kind) begin
						cmd.load_hist = 1'b1;
					end else if (frame_start || status.header_next) begin
						cmd.load_hdr = 1'b1;
					end else begin
						cmd.calc_hi = 1'b1;
						state_d     = ST_LOW;
					end
				end
			end
			ST_LOW: begin
				in_stall = 1'b1;
				if (out_free) begin
					cmd.calc_lo = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// a sample is never written over one that still waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.calc_hi || cmd.calc_lo) |-> !(out_valid_q && out_stall))
		else $error("sample register overwritten while stalled");

	// the high nibble is always followed by the low nibble state
	a_hi_then_low: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.calc_hi |=> (state_q == ST_LOW))
		else $error("high nibble not followed by low nibble");

	// after the low nibble the block is ready for the next byte
	a_low_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.calc_lo |=> (state_q == ST_IDLE) && out_valid_q)
		else $error("low nibble did not finish the byte");

endmodule

@@ rtl/gcad_datapath.sv @@
// ----------------------------------------------------------------------------
// gcad_datapath
// Coefficient registers, frame state, history and the nibble filter.
// ----------------------------------------------------------------------------
module gcad_datapath
	import gcad_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic [7:0]                 data_byte,
	input  logic signed [SAMPLE_W-1:0] history_newest,
	input  logic signed [SAMPLE_W-1:0] history_older,
	input  gcad_cmd_t                  cmd,
	output gcad_status_t               status,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic                       pair_last
);

	logic [CFG_DATA_W-1:0]      coef_q [NUM_COEF_PAIRS];
	logic signed [SAMPLE_W-1:0] newest_q, older_q;
	logic [SHIFT_W-1:0]         shift_q;
	logic [COEF_IDX_W-1:0]      coef_idx_q;
	logic [POS_W-1:0]           pos_q;
	logic [3:0]                 low_nib_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       pair_last_q;

	logic [3:0]                 nib;
	logic signed [NIB_EXT_W-1:0] nib_ext, nib_shifted;
	logic signed [SAMPLE_W-1:0] c1, c2;
	logic signed [31:0]         prod1, prod2;
	logic signed [ACC_W-1:0]    acc;
	logic signed [RES_W-1:0]    res;
	logic signed [SAMPLE_W-1:0] res_sat;
	logic                       calc;

	assign calc = cmd.calc_hi || cmd.calc_lo;
	assign status.header_next = (pos_q == '0);

	// high nibble comes straight from the port, low nibble was held
	assign nib         = cmd.calc_hi ? data_byte[7:4] : low_nib_q;
	assign nib_ext     = {{(NIB_EXT_W-4){nib[3]}}, nib};
	assign nib_shifted = nib_ext <<< shift_q;

	assign c1    = coef_q[coef_idx_q][31:16];
	assign c2    = coef_q[coef_idx_q][15:0];
	assign prod1 = c1 * newest_q;
	assign prod2 = c2 * older_q;

	assign acc = {{(ACC_W-NIB_EXT_W-FRAC_W){nib_shifted[NIB_EXT_W-1]}},
			nib_shifted, {FRAC_W{1'b0}}}
		+ ROUND_BIAS
		+ {{(ACC_W-32){prod1[31]}}, prod1}
		+ {{(ACC_W-32){prod2[31]}}, prod2};

	// floor shift is the upper slice of the sum
	assign res = acc[ACC_W-1:FRAC_W];

	always_comb begin
		if (res > SAT_MAX) begin
			res_sat = SAT_MAX[SAMPLE_W-1:0];
		end else if (res < SAT_MIN) begin
			res_sat = SAT_MIN[SAMPLE_W-1:0];
		end else begin
			res_sat = res[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF_PAIRS; i++) begin
				coef_q[i] <= '0;
			end
			newest_q   <= '0;
			older_q    <= '0;
			shift_q    <= '0;
			coef_idx_q <= '0;
			pos_q      <= '0;
		end else begin
			if (cfg_we && (cfg_index < CFG_INDEX_W'(NUM_COEF_PAIRS))) begin
				coef_q[cfg_index[COEF_IDX_W-1:0]] <= cfg_data;
			end
			if (cmd.load_hist) begin
				newest_q <= history_newest;
				older_q  <= history_older;
			end else if (calc) begin
				older_q  <= newest_q;
				newest_q <= res_sat;
			end
			if (cmd.load_hdr) begin
				shift_q    <= data_byte[3:0];
				coef_idx_q <= data_byte[6:4];
				pos_q      <= POS_W'(1);
			end else if (cmd.calc_lo) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.calc_hi) begin
			low_nib_q <= data_byte[3:0];
		end
		if (calc) begin
			sample_q    <= res_sat;
			pair_last_q <= cmd.calc_lo;
		end
	end

	assign sample    = sample_q;
	assign pair_last = pair_last_q;

endmodule

@@ rtl/gc_adpcm_decoder_core.sv @@
// ----------------------------------------------------------------------------
// gc_adpcm_decoder_core
// GC-ADPCM frame decoder: one stream byte per input beat, two samples out
// for each data byte.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | kind, data_byte, frame_start,
//          |                      | history_newest, history_older
//  out     | out_valid / out_stall| sample, pair_last
//  cfg     | cfg_we               | cfg_index, cfg_data (coef pairs 0..7)
//
//  the high nibble of a data byte is filtered in the accept cycle, the low
//  nibble once the output register is free; one filter pass per cycle while
//  the output is not stalled, since each sample feeds the history of the next
//  header and history-load beats produce no sample
//  reset clears history, frame position, shift, coef index and coef pairs
//  a stalled output holds the sample register; the filter and the input
//  wait until the waiting sample is taken
//
module gc_adpcm_decoder_core
	import gcad_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	// input beats
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       kind,
	input  logic [7:0]                 data_byte,
	input  logic                       frame_start,
	input  logic signed [SAMPLE_W-1:0] history_newest,
	input  logic signed [SAMPLE_W-1:0] history_older,
	// output beats
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic                       pair_last
);

	gcad_cmd_t    cmd;
	gcad_status_t status;

	// sequencer: decides header / history / data and paces the nibbles
	gcad_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.cmd         (cmd)
	);

	// filter, history, frame state and the sample register
	gcad_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.data_byte      (data_byte),
		.history_newest (history_newest),
		.history_older  (history_older),
		.cmd            (cmd),
		.status         (status),
		.sample         (sample),
		.pair_last      (pair_last)
	);

endmodule

@@ sim/gc_adpcm_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gc_adpcm_decoder_core_tb
// Self-checking bench for the GC-ADPCM decoder core: a queue-fed driver
// pushes stream bytes and history loads, a scoreboard predicts every
// decoded sample and a monitor compares the output beats in order.
// ----------------------------------------------------------------------------
module gc_adpcm_decoder_core_tb;
	import gcad_pkg::*;

	localparam logic KIND_STREAM  = 1'b0;
	localparam logic KIND_HISTORY = 1'b1;
	localparam int   SETTLE_CYCLES = 6;
	localparam int   WATCHDOG_LIMIT = 2000; // cycles without any beat on either side
	localparam int   MAX_REPORTS = 10;
	localparam int   SPARE_INDEX_MAX = (1 << CFG_INDEX_W) - 1;

	// one input beat
	typedef struct {
		logic                       kind;
		logic [7:0]                 data_byte;
		logic                       frame_start;
		logic signed [SAMPLE_W-1:0] hist_newest;
		logic signed [SAMPLE_W-1:0] hist_older;
	} beat_t;

	// one decoded sample
	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic                       pair_last;
	} pcm_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       kind = 1'b0;
	logic [7:0]                 data_byte = '0;
	logic                       frame_start = 1'b0;
	logic signed [SAMPLE_W-1:0] history_newest = '0;
	logic signed [SAMPLE_W-1:0] history_older = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       pair_last;

	gc_adpcm_decoder_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.data_byte      (data_byte),
		.frame_start    (frame_start),
		.history_newest (history_newest),
		.history_older  (history_older),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.sample         (sample),
		.pair_last      (pair_last)
	);

	always #5 clk = ~clk;

	// stimulus and scoreboard storage
	beat_t byte_queue[$];
	pcm_t  sample_queue[$];

	// predicted decoder state
	logic [CFG_DATA_W-1:0]      coef_table [NUM_COEF_PAIRS];
	logic [CFG_DATA_W-1:0]      coef_plan  [NUM_COEF_PAIRS];
	logic signed [SAMPLE_W-1:0] pred_newest = '0;
	logic signed [SAMPLE_W-1:0] pred_older = '0;
	logic [SHIFT_W-1:0]         pred_shift = '0;
	logic [COEF_IDX_W-1:0]      pred_coef_idx = '0;
	logic [POS_W-1:0]           pred_pos = '0;

	// frame position as the generator sees it, used to build sane frames
	logic [POS_W-1:0] gen_pos = '0;

	// run bookkeeping
	int    errors = 0;
	int    beats_in = 0;
	int    samples_checked = 0;
	int    settings_used = 0;
	int    idle_cycles = 0;
	int    in_idle_pct = 0;
	int    out_idle_pct = 0;
	int    gap_left = 0;
	int    stall_left = 0;
	logic  beat_taken = 1'b0;
	beat_t next_beat;

	initial begin
		for (int i = 0; i < NUM_COEF_PAIRS; i++) begin
			coef_table[i] = '0;
		end
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// one filter pass: sign-extend and shift the nibble, 11-bit fixed point
	// sum with both history taps, floor shift, saturate, update history
	function automatic logic signed [SAMPLE_W-1:0] filter_nibble(input logic [3:0] nib);
		longint x;
		longint c1;
		longint c2;
		longint acc;
		longint r;
		x = longint'(nib);
		if (x >= 8) begin
			x = x - 16;
		end
		x = x << pred_shift;
		c1 = longint'($signed(coef_table[pred_coef_idx][31:16]));
		c2 = longint'($signed(coef_table[pred_coef_idx][15:0]));
		acc = x * 2048 + 1024 + c1 * longint'(pred_newest) + c2 * longint'(pred_older);
		r = acc >>> FRAC_W;
		if (r > 32767) begin
			r = 32767;
		end
		if (r < -32768) begin
			r = -32768;
		end
		pred_older  = pred_newest;
		pred_newest = r[SAMPLE_W-1:0];
		return r[SAMPLE_W-1:0];
	endfunction

	// advance the predicted state by one accepted beat and queue its samples
	function automatic void decode_beat(input beat_t b);
		pcm_t s;
		if (b.kind == KIND_HISTORY) begin
			pred_newest = b.hist_newest;
			pred_older  = b.hist_older;
		end else if (b.frame_start || pred_pos == 0) begin
			// header: bit 7 is don't-care
			pred_shift    = b.data_byte[3:0];
			pred_coef_idx = b.data_byte[6:4];
			pred_pos      = POS_W'(1);
		end else begin
			s.value     = filter_nibble(b.data_byte[7:4]);
			s.pair_last = 1'b0;
			sample_queue.push_back(s);
			s.value     = filter_nibble(b.data_byte[3:0]);
			s.pair_last = 1'b1;
			sample_queue.push_back(s);
			pred_pos = pred_pos + 1'b1; // wraps to 0 after seven data bytes, so the next byte is a header
		end
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	task automatic push_beat(input beat_t b);
		if (b.kind == KIND_STREAM) begin
			if (b.frame_start || gen_pos == 0) begin
				gen_pos = POS_W'(1);
			end else begin
				gen_pos = gen_pos + 1'b1;
			end
		end
		byte_queue.push_back(b);
	endtask

	// stream byte; the history fields carry random junk
	task automatic push_stream(input logic [7:0] value, input logic start);
		beat_t b;
		b.kind        = KIND_STREAM;
		b.data_byte   = value;
		b.frame_start = start;
		b.hist_newest = SAMPLE_W'($urandom());
		b.hist_older  = SAMPLE_W'($urandom());
		push_beat(b);
	endtask

	// history load; the byte and start flag carry random junk
	task automatic push_history(input logic signed [SAMPLE_W-1:0] newest,
			input logic signed [SAMPLE_W-1:0] older);
		beat_t b;
		b.kind        = KIND_HISTORY;
		b.data_byte   = 8'($urandom());
		b.frame_start = 1'($urandom());
		b.hist_newest = newest;
		b.hist_older  = older;
		push_beat(b);
	endtask

	// mostly complete or short frames with random content, plus some
	// history loads and fully random beats
	task automatic queue_random_beats(input int count);
		int n;
		int len;
		int roll;
		beat_t b;
		n = 0;
		while (n < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 75) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 7;
				push_stream(8'($urandom()),
					(gen_pos == 0) ? 1'($urandom_range(0, 1)) : 1'b1);
				n++;
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 19) == 0) begin
						push_history(SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
						n++;
					end
					push_stream(8'($urandom()), 1'b0);
					n++;
				end
			end else if (roll < 85) begin
				push_history(SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
				n++;
			end else begin
				b.kind        = 1'($urandom());
				b.data_byte   = 8'($urandom());
				b.frame_start = 1'($urandom());
				b.hist_newest = SAMPLE_W'($urandom());
				b.hist_older  = SAMPLE_W'($urandom());
				push_beat(b);
				n++;
			end
		end
	endtask

	// write coef_plan to all eight pairs, then one unused index
	task automatic program_coefs();
		int unsigned spare;
		spare = $urandom_range(NUM_COEF_PAIRS, SPARE_INDEX_MAX);
		for (int i = 0; i <= NUM_COEF_PAIRS; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			if (i < NUM_COEF_PAIRS) begin
				cfg_index <= CFG_INDEX_W'(i);
				cfg_data <= coef_plan[i];
				coef_table[i] = coef_plan[i];
			end else begin
				// unused index, the decoder must ignore it
				cfg_index <= CFG_INDEX_W'(spare);
				cfg_data <= $urandom();
			end
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// hold the sender until every queued beat and predicted sample is gone
	task automatic wait_drained();
		do
			@(negedge clk);
		while (byte_queue.size() != 0 || in_valid || sample_queue.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// signed 16-bit coefficient in a typical range
	function automatic logic [15:0] mild_coef();
		logic [15:0] v;
		v = 16'($urandom_range(0, 4096));
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic logic [15:0] extreme_coef();
		case ($urandom_range(0, 3))
			0: begin
				return 16'h7FFF;
			end
			1: begin
				return 16'h8000;
			end
			2: begin
				return 16'hFFFF;
			end
			default: begin
				return 16'h0000;
			end
		endcase
	endfunction

	task automatic note_failure(input string what);
		errors++;
		if (errors <= MAX_REPORTS) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
	endtask

	// ------------------------------------------------------------------------
	// driver: a new beat only once the previous one has been taken
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!in_valid || beat_taken)) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (byte_queue.size() != 0 && in_idle_pct != 0
					&& $urandom_range(0, 99) < in_idle_pct) begin
				// gap burst, its remaining length counted in gap_left
				in_valid <= 1'b0;
				gap_left <= $urandom_range(0, 8);
			end else if (byte_queue.size() != 0) begin
				next_beat = byte_queue.pop_front();
				in_valid <= 1'b1;
				kind <= next_beat.kind;
				data_byte <= next_beat.data_byte;
				frame_start <= next_beat.frame_start;
				history_newest <= next_beat.hist_newest;
				history_older <= next_beat.hist_older;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall bursts, their remaining length counted in stall_left
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 8);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// monitor: predict on every accepted input beat first, then check the
	// output beat of the same edge against the oldest expected sample
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		pcm_t want;
		beat_t got_in;
		beat_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			got_in.kind        = kind;
			got_in.data_byte   = data_byte;
			got_in.frame_start = frame_start;
			got_in.hist_newest = history_newest;
			got_in.hist_older  = history_older;
			decode_beat(got_in);
			beats_in++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (sample_queue.size() == 0) begin
				note_failure($sformatf("sample %0d pair_last %0b with none expected",
					sample, pair_last));
			end else begin
				want = sample_queue.pop_front();
				if (sample !== want.value || pair_last !== want.pair_last) begin
					note_failure($sformatf("sample %0d pair_last %0b, expected %0d / %0b",
						sample, pair_last, want.value, want.pair_last));
				end
				samples_checked++;
			end
		end
	end

	// watchdog on stretches without any beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d samples outstanding",
				idle_cycles, sample_queue.size());
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// the very first byte has no frame_start: a header by position alone,
		// decoded with the all-zero coefficients out of reset
		in_idle_pct = 20;
		out_idle_pct = 10;
		push_stream(8'h00, 1'b0);
		push_stream(8'h7F, 1'b0);
		wait_drained();

		// extreme coefficient pairs
		coef_plan[0] = 32'h7FFF_7FFF;
		coef_plan[1] = 32'h8000_8000;
		coef_plan[2] = 32'h7FFF_8000;
		coef_plan[3] = 32'h8000_7FFF;
		coef_plan[4] = 32'hFFFF_FFFF;
		coef_plan[5] = 32'h0800_0000;
		coef_plan[6] = 32'h1000_F800;
		coef_plan[7] = 32'h0000_0000;
		program_coefs();

		// directed: saturation both ways, header bit 7, history load mid
		// frame, wrap into an implicit header, short runs
		push_stream(8'h80, 1'b0);
		push_history(16'sh7FFF, 16'sh7FFF);
		push_stream(8'h00, 1'b0);
		push_history(-16'sh8000, -16'sh8000);
		push_stream(8'h88, 1'b0);
		push_stream(8'hDF, 1'b1);
		push_stream(8'h77, 1'b0);
		push_stream(8'h88, 1'b0);
		push_history(16'sh1234, -16'sh0001);
		push_stream(8'hFF, 1'b0);
		push_stream(8'h01, 1'b0);
		push_stream(8'h10, 1'b0);
		push_stream(8'hF0, 1'b0);
		push_stream(8'h96, 1'b0);
		push_stream(8'h6A, 1'b0);
		push_stream(8'h5A, 1'b0);
		push_stream(8'h4F, 1'b1);
		push_stream(8'h7F, 1'b0);
		push_stream(8'h3C, 1'b1);
		push_stream(8'h81, 1'b0);
		push_stream(8'h2E, 1'b1);
		push_stream(8'hE7, 1'b0);
		wait_drained();

		// fully random pairs
		for (int i = 0; i < NUM_COEF_PAIRS; i++) begin
			coef_plan[i] = $urandom();
		end
		program_coefs();
		in_idle_pct = 25;
		out_idle_pct = 12;
		queue_random_beats(140);
		wait_drained();

		// pairs drawn from the 16-bit extremes
		for (int i = 0; i < NUM_COEF_PAIRS; i++) begin
			coef_plan[i] = {extreme_coef(), extreme_coef()};
		end
		program_coefs();
		in_idle_pct = 10;
		out_idle_pct = 25;
		queue_random_beats(120);
		wait_drained();

		// realistic predictor taps
		for (int i = 0; i < NUM_COEF_PAIRS; i++) begin
			coef_plan[i] = {mild_coef(), mild_coef()};
		end
		program_coefs();
		in_idle_pct = 15;
		out_idle_pct = 5;
		queue_random_beats(130);
		wait_drained();

		// all zero again, written explicitly, and no idling on either side
		for (int i = 0; i < NUM_COEF_PAIRS; i++) begin
			coef_plan[i] = '0;
		end
		program_coefs();
		in_idle_pct = 0;
		out_idle_pct = 0;
		queue_random_beats(100);
		wait_drained();

		if (sample_queue.size() != 0) begin
			note_failure($sformatf("%0d samples never arrived", sample_queue.size()));
		end
		$display("decoded %0d input beats under %0d coefficient settings",
			beats_in, settings_used);
		$display("checked %0d samples, %0d mismatches", samples_checked, errors);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
